// File: hdl/hbr_pkg.sv
// Package for the heightmap bilinear resampler: sizes, codes, shared types
// and the target-size helper functions.
// Depends on nothing; every other file but hbr_ram uses it by scoped names.
`default_nettype none

package hbr_pkg;

  // Sizes
  localparam int MAX_SOURCE_SIDE = 256;
  localparam int MIN_TARGET_SIDE = 33;
  localparam int MAX_TARGET_SIDE = 1025;
  localparam int STORE_DEPTH     = MAX_SOURCE_SIDE * MAX_SOURCE_SIDE;
  localparam int SAMPLE_W        = 16;
  localparam int COORD_W         = 8;
  localparam int DST_W           = 11;
  localparam int SIDE_W          = 9;
  localparam int K_W             = 4;
  localparam int FRAC_W          = 16;
  localparam int HEIGHT_W        = 24;
  localparam int CFG_IDX_W       = 3;
  localparam int OUTQ_DEPTH      = 4;
  localparam int K_MIN           = $clog2(MIN_TARGET_SIDE - 1);
  localparam int K_MAX           = $clog2(MAX_TARGET_SIDE - 1);

  // Item kinds carried on the input tuser
  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 3'd0,
    REG_SOURCE_HEIGHT = 3'd1,
    REG_EIGHT_BIT     = 3'd2,
    REG_FLIP_VERTICAL = 3'd3,
    REG_MIN_HEIGHT    = 3'd4,
    REG_MAX_HEIGHT    = 3'd5
  } cfg_reg_t;

  // Geometry settings derived from configuration
  typedef struct packed {
    logic [SIDE_W-1:0] sw;
    logic [SIDE_W-1:0] sh;
    logic [K_W-1:0]    kw;
    logic [K_W-1:0]    kh;
    logic              eight;
    logic              flip;
  } geom_t;

  // Tag that travels with each store read
  typedef struct packed {
    logic              vld;
    logic [1:0]        idx;
    logic [FRAC_W-1:0] tx;
    logic [FRAC_W-1:0] ty;
  } rd_tag_t;

  // One result item
  typedef struct packed {
    logic [HEIGHT_W-1:0] height;
    logic [DST_W-1:0]    tw;
    logic [DST_W-1:0]    th;
    logic                rerr;
  } out_item_t;

  // Source side as used: zero acts as one, large values saturate
  function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] s);
    logic [SIDE_W-1:0] r;
    r = s;
    if (s == '0) r = SIDE_W'(1);
    else if (s > SIDE_W'(MAX_SOURCE_SIDE)) r = SIDE_W'(MAX_SOURCE_SIDE);
    return r;
  endfunction

  // Exponent k of the nearest target side 2^k+1; a tie keeps the smaller
  function automatic logic [K_W-1:0] target_log2(input logic [SIDE_W-1:0] s);
    int k;
    int c;
    int d;
    int best_d;
    logic [K_W-1:0] best;
    best   = K_W'(K_MIN);
    best_d = 1 << 30;
    for (k = K_MIN; k <= K_MAX; k++) begin
      c = (1 << k) + 1;
      d = (c > int'(s)) ? c - int'(s) : int'(s) - c;
      if (d < best_d) begin
        best   = K_W'(k);
        best_d = d;
      end
    end
    return best;
  endfunction

endpackage

`default_nettype wire

// File: hdl/heightmap_bilinear_resampler_unit.sv
// Heightmap bilinear resampler, top level: configuration registers, target
// size selection, credit count and module wiring. Uses hbr_pkg and all hbr_*.
//
// Usage:
//  - s_axis carries items: tuser = op (load or query), tdata holds the fields.
//    A load writes one 16-bit sample into the 256x256 sample store and gives
//    no result; a query gives exactly one result on m_axis.
//  - cfg_valid/cfg_data/cfg_index write one register per transfer; cfg_ready
//    is always high. Write only while no item is in flight.
//  - Loads are taken one per cycle. A query makes four reads of the single
//    store read port (one per neighbour); the next item can be held while
//    they are issued, and a load behind a query waits until its reads are issued.
//  - At most four queries are in flight or queued; when the receiver stalls
//    m_axis, results wait in the queue and new query reads pause, then
//    s_axis tready drops. Nothing is lost.
//  - Reset (rst, synchronous) restores register defaults and empties the
//    pipeline; the sample store is not cleared and must be loaded first.
`default_nettype none

module heightmap_bilinear_resampler_unit #(
  parameter int OUTQ_DEPTH = hbr_pkg::OUTQ_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [7:0] src_x, [15:8] src_y, [31:16] sample, [42:32] dst_x, [53:43] dst_y
  input  wire logic [55:0]                       s_axis_tdata,
  // [0] op
  input  wire logic [0:0]                        s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [23:0] height, [34:24] target_width, [45:35] target_height
  output logic [47:0]                            m_axis_tdata,
  // [0] range_error
  output logic [0:0]                             m_axis_tuser,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [hbr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [hbr_pkg::HEIGHT_W-1:0]      cfg_data
);

  localparam int CRED_W = $clog2(OUTQ_DEPTH + 1);

  logic [hbr_pkg::SIDE_W-1:0]          source_width, source_height;
  logic                                eight_bit_samples, flip_vertical;
  logic signed [hbr_pkg::HEIGHT_W-1:0] min_height, max_height;

  hbr_pkg::geom_t                      geom;
  hbr_pkg::rd_tag_t                    tag;
  hbr_pkg::out_item_t                  q_in, q_out;
  logic [hbr_pkg::DST_W-1:0]           tw, th;
  logic [hbr_pkg::HEIGHT_W:0]          span_w;
  logic                                rerr;

  logic                                wr_en, rd_en, start, credit_ok;
  logic [2*hbr_pkg::COORD_W-1:0]       wr_addr, rd_addr;
  logic [hbr_pkg::SAMPLE_W-1:0]        wr_data, rd_data;
  logic                                res_v;
  logic [hbr_pkg::HEIGHT_W-1:0]        res_height;
  logic [CRED_W-1:0]                   inflight;
  logic                                pop;

  // Configuration writes
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      source_width      <= hbr_pkg::SIDE_W'(256);
      source_height     <= hbr_pkg::SIDE_W'(256);
      eight_bit_samples <= 1'b0;
      flip_vertical     <= 1'b0;
      min_height        <= '0;
      max_height        <= hbr_pkg::HEIGHT_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hbr_pkg::REG_SOURCE_WIDTH:  source_width      <= cfg_data[hbr_pkg::SIDE_W-1:0];
        hbr_pkg::REG_SOURCE_HEIGHT: source_height     <= cfg_data[hbr_pkg::SIDE_W-1:0];
        hbr_pkg::REG_EIGHT_BIT:     eight_bit_samples <= cfg_data[0];
        hbr_pkg::REG_FLIP_VERTICAL: flip_vertical     <= cfg_data[0];
        hbr_pkg::REG_MIN_HEIGHT:    min_height        <= $signed(cfg_data);
        hbr_pkg::REG_MAX_HEIGHT:    max_height        <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Derived geometry and height range
  always_comb begin
    geom.sw    = hbr_pkg::eff_side(source_width);
    geom.sh    = hbr_pkg::eff_side(source_height);
    geom.kw    = hbr_pkg::target_log2(geom.sw);
    geom.kh    = hbr_pkg::target_log2(geom.sh);
    geom.eight = eight_bit_samples;
    geom.flip  = flip_vertical;
    tw         = (hbr_pkg::DST_W'(1) << geom.kw) + hbr_pkg::DST_W'(1);
    th         = (hbr_pkg::DST_W'(1) << geom.kh) + hbr_pkg::DST_W'(1);
    rerr       = max_height <= min_height;
    span_w     = 25'(max_height) - 25'(min_height);
  end

  // Credits: queries whose reads started and whose result is not yet taken
  assign pop       = m_axis_tvalid && m_axis_tready;
  assign credit_ok = inflight < CRED_W'(OUTQ_DEPTH);
  always_ff @(posedge clk) begin
    if (rst) inflight <= '0;
    else     inflight <= inflight + CRED_W'(start) - CRED_W'(pop);
  end

  hbr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tuser[0]),
    .in_src_x  (s_axis_tdata[7:0]),
    .in_src_y  (s_axis_tdata[15:8]),
    .in_sample (s_axis_tdata[31:16]),
    .in_dst_x  (s_axis_tdata[42:32]),
    .in_dst_y  (s_axis_tdata[53:43]),
    .geom      (geom),
    .credit_ok (credit_ok),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .tag       (tag),
    .start     (start)
  );

  hbr_ram #(
    .WIDTH (hbr_pkg::SAMPLE_W),
    .DEPTH (hbr_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  hbr_interp u_interp (
    .clk        (clk),
    .rst        (rst),
    .tag        (tag),
    .rd_data    (rd_data),
    .min_height (min_height),
    .span       (span_w[hbr_pkg::HEIGHT_W-1:0]),
    .res_v      (res_v),
    .res_height (res_height)
  );

  // Result item; range error forces height zero
  always_comb begin
    q_in.height = rerr ? '0 : res_height;
    q_in.tw     = tw;
    q_in.th     = th;
    q_in.rerr   = rerr;
  end

  hbr_outq #(
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (res_v),
    .wr_item   (q_in),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_item  (q_out)
  );

  assign m_axis_tdata = {2'b00, q_out.th, q_out.tw, q_out.height};
  assign m_axis_tuser = q_out.rerr;

`ifndef SYNTHESIS
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    inflight <= CRED_W'(OUTQ_DEPTH)) else $error("credit count exceeds queue depth");
  a_valid_has_credit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> inflight != '0) else $error("result shown without credit");
  a_start_has_credit: assert property (@(posedge clk) disable iff (rst)
    start |-> credit_ok) else $error("query reads started without credit");
`endif

endmodule

`default_nettype wire

// File: hdl/hbr_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module hbr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns old data on a same-address write
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/hbr_front.sv
// Input stage and read sequencer: holds one item, writes loads into the
// sample store and issues four store reads per query. Uses hbr_pkg.
`default_nettype none

module hbr_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_op,
  input  wire logic [hbr_pkg::COORD_W-1:0]    in_src_x,
  input  wire logic [hbr_pkg::COORD_W-1:0]    in_src_y,
  input  wire logic [hbr_pkg::SAMPLE_W-1:0]   in_sample,
  input  wire logic [hbr_pkg::DST_W-1:0]      in_dst_x,
  input  wire logic [hbr_pkg::DST_W-1:0]      in_dst_y,
  input  wire hbr_pkg::geom_t                 geom,
  input  wire logic                           credit_ok,
  output logic                                wr_en,
  output logic [2*hbr_pkg::COORD_W-1:0]       wr_addr,
  output logic [hbr_pkg::SAMPLE_W-1:0]        wr_data,
  output logic                                rd_en,
  output logic [2*hbr_pkg::COORD_W-1:0]       rd_addr,
  output hbr_pkg::rd_tag_t                    tag,
  output logic                                start
);

  typedef struct packed {
    logic [hbr_pkg::COORD_W-1:0] base;
    logic [hbr_pkg::COORD_W-1:0] next;
    logic [hbr_pkg::FRAC_W-1:0]  frac;
  } axis_t;

  // Proportional mapping onto the source; the target side minus one is 2^k
  function automatic axis_t map_axis(input logic [hbr_pkg::DST_W-1:0]  d,
                                     input logic [hbr_pkg::K_W-1:0]    k,
                                     input logic [hbr_pkg::SIDE_W-1:0] s);
    logic [18:0] num;
    logic [18:0] mask;
    logic [26:0] fr;
    logic [hbr_pkg::SIDE_W-1:0] b1;
    axis_t r;
    num    = 19'(d) * 19'(s - hbr_pkg::SIDE_W'(1));
    mask   = (19'(1) << k) - 19'(1);
    fr     = 27'(num & mask) << (5'd16 - 5'(k));
    r.base = hbr_pkg::COORD_W'(num >> k);
    b1     = {1'b0, r.base} + hbr_pkg::SIDE_W'(1);
    r.next = (b1 < s) ? b1[hbr_pkg::COORD_W-1:0]
                      : hbr_pkg::COORD_W'(s - hbr_pkg::SIDE_W'(1));
    r.frac = fr[hbr_pkg::FRAC_W-1:0];
    return r;
  endfunction

  // Held item
  logic                          acc_v;
  logic                          acc_op;
  logic [hbr_pkg::COORD_W-1:0]   acc_sx;
  logic [hbr_pkg::COORD_W-1:0]   acc_sy;
  logic [hbr_pkg::SAMPLE_W-1:0]  acc_smp;
  logic [hbr_pkg::DST_W-1:0]     acc_dx;
  logic [hbr_pkg::DST_W-1:0]     acc_dy;

  // Sequencer
  logic                          seq_v;
  logic [1:0]                    seq_cnt;
  logic [hbr_pkg::COORD_W-1:0]   x0, x1, y0, y1;
  logic [hbr_pkg::FRAC_W-1:0]    tx, ty;

  logic                          issue;
  logic                          seq_free;
  logic                          acc_go;
  logic [hbr_pkg::DST_W-1:0]     tmax_x, tmax_y, dxc, dyc;
  axis_t                         ax, ay;

  assign issue    = seq_v && (seq_cnt != 2'd0 || credit_ok);
  assign seq_free = !seq_v || (issue && seq_cnt == 2'd3);
  assign acc_go   = acc_v && ((acc_op == hbr_pkg::OP_LOAD) ? !seq_v : seq_free);
  assign in_ready = !acc_v || acc_go;
  assign start    = issue && seq_cnt == 2'd0;

  // Load write; eight-bit samples are widened here
  assign wr_en   = acc_go && acc_op == hbr_pkg::OP_LOAD;
  assign wr_addr = {acc_sy, acc_sx};
  assign wr_data = geom.eight ? {acc_smp[7:0], acc_smp[7:0]} : acc_smp;

  // Clamp, flip and map the query point
  always_comb begin
    tmax_x = hbr_pkg::DST_W'(1) << geom.kw;
    tmax_y = hbr_pkg::DST_W'(1) << geom.kh;
    dxc    = (acc_dx > tmax_x) ? tmax_x : acc_dx;
    dyc    = (acc_dy > tmax_y) ? tmax_y : acc_dy;
    if (geom.flip) dyc = tmax_y - dyc;
    ax = map_axis(dxc, geom.kw, geom.sw);
    ay = map_axis(dyc, geom.kh, geom.sh);
  end

  // Read address per step: (x0,y0) (x1,y0) (x0,y1) (x1,y1)
  always_comb begin
    rd_en   = issue;
    rd_addr = {seq_cnt[1] ? y1 : y0, seq_cnt[0] ? x1 : x0};
    tag.vld = issue;
    tag.idx = seq_cnt;
    tag.tx  = tx;
    tag.ty  = ty;
  end

  // Held item register
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_v <= 1'b0;
    end else if (in_valid && in_ready) begin
      acc_v <= 1'b1;
    end else if (acc_go) begin
      acc_v <= 1'b0;
    end
    if (in_valid && in_ready) begin
      acc_op  <= in_op;
      acc_sx  <= in_src_x;
      acc_sy  <= in_src_y;
      acc_smp <= in_sample;
      acc_dx  <= in_dst_x;
      acc_dy  <= in_dst_y;
    end
  end

  // Sequencer register
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_v   <= 1'b0;
      seq_cnt <= 2'd0;
    end else if (acc_go && acc_op == hbr_pkg::OP_QUERY) begin
      seq_v   <= 1'b1;
      seq_cnt <= 2'd0;
    end else if (issue) begin
      seq_cnt <= seq_cnt + 2'd1;
      if (seq_cnt == 2'd3) seq_v <= 1'b0;
    end
    if (acc_go && acc_op == hbr_pkg::OP_QUERY) begin
      x0 <= ax.base;
      x1 <= ax.next;
      tx <= ax.frac;
      y0 <= ay.base;
      y1 <= ay.next;
      ty <= ay.frac;
    end
  end

`ifndef SYNTHESIS
  a_no_load_during_reads: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !rd_en) else $error("load written while query reads pending");
`endif

endmodule

`default_nettype wire

// File: hdl/hbr_interp.sv
// Bilinear interpolation and height mapping pipeline fed by store reads.
// Uses hbr_pkg.
`default_nettype none

module hbr_interp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire hbr_pkg::rd_tag_t                    tag,
  input  wire logic [hbr_pkg::SAMPLE_W-1:0]        rd_data,
  input  wire logic signed [hbr_pkg::HEIGHT_W-1:0] min_height,
  input  wire logic [hbr_pkg::HEIGHT_W-1:0]        span,
  output logic                                     res_v,
  output logic [hbr_pkg::HEIGHT_W-1:0]             res_height
);

  // a*65536 + (b-a)*f, exact and non-negative
  function automatic logic [31:0] row_mix(input logic [15:0] a,
                                          input logic [15:0] b,
                                          input logic [15:0] f);
    logic signed [16:0] diff;
    logic signed [34:0] sum;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    sum  = $signed({3'b000, a, 16'h0000}) + 35'(diff) * 35'($signed({1'b0, f}));
    return sum[31:0];
  endfunction

  hbr_pkg::rd_tag_t tag_q;
  logic [15:0]      a0, a1;
  logic [31:0]      r0;
  logic             s1_v, s2_v, s3_v, s4_v;
  logic [31:0]      s1_r0, s1_r1;
  logic [15:0]      s1_ty;
  logic [47:0]      s2_v_val;
  logic [55:0]      s3_p;
  logic [40:0]      s4_x;
  logic [25:0]      s4_q0;

  logic signed [32:0] d_r;
  logic signed [49:0] v_sum;
  logic [48:0]        v_rnd;
  logic [31:0]        w;
  logic [56:0]        p_rnd;
  logic [40:0]        x;
  logic [41:0]        q_sum;
  logic [41:0]        rem;
  logic [25:0]        q;
  logic [24:0]        h_sum;

  always_comb begin
    d_r   = $signed({1'b0, s1_r1}) - $signed({1'b0, s1_r0});
    v_sum = $signed({2'b00, s1_r0, 16'h0000}) + 50'(d_r) * 50'($signed({1'b0, s1_ty}));
    v_rnd = 49'(s2_v_val) + 49'd32768;
    w     = v_rnd[47:16];
    // divide by 65535*65536 with rounding: shift, then reciprocal series
    p_rnd = 57'(s3_p) + 57'(32'h7FFF_8000);
    x     = p_rnd[56:16];
    q_sum = 42'(x) + 42'(x >> 16) + 42'(x >> 32);
    rem   = 42'(s4_x) - {s4_q0, 16'h0000} + 42'(s4_q0);
    q     = (rem >= 42'd65535) ? s4_q0 + 26'd1 : s4_q0;
    h_sum = 25'(min_height) + 25'(q[23:0]);
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_q.vld <= 1'b0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      s4_v      <= 1'b0;
      res_v     <= 1'b0;
    end else begin
      tag_q.vld <= tag.vld;
      s1_v      <= tag_q.vld && tag_q.idx == 2'd3;
      s2_v      <= s1_v;
      s3_v      <= s2_v;
      s4_v      <= s3_v;
      res_v     <= s4_v;
    end
  end

  // Data path
  always_ff @(posedge clk) begin
    tag_q.idx <= tag.idx;
    tag_q.tx  <= tag.tx;
    tag_q.ty  <= tag.ty;
    if (tag_q.vld) begin
      case (tag_q.idx)
        2'd0:    a0 <= rd_data;
        2'd1:    r0 <= row_mix(a0, rd_data, tag_q.tx);
        2'd2:    a1 <= rd_data;
        default: begin
          s1_r0 <= r0;
          s1_r1 <= row_mix(a1, rd_data, tag_q.tx);
          s1_ty <= tag_q.ty;
        end
      endcase
    end
    s2_v_val   <= v_sum[47:0];
    s3_p       <= 56'(span) * 56'(w);
    s4_x       <= x;
    s4_q0      <= q_sum[41:16];
    res_height <= h_sum[23:0];
  end

endmodule

`default_nettype wire

// File: hdl/hbr_outq.sv
// Result queue between the pipeline and the output channel.
// Uses hbr_pkg.
`default_nettype none

module hbr_outq #(
  parameter int DEPTH = hbr_pkg::OUTQ_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr_en,
  input  wire hbr_pkg::out_item_t  wr_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output hbr_pkg::out_item_t       out_item
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  hbr_pkg::out_item_t mem [DEPTH];
  logic [PTR_W-1:0]   wptr, rptr;
  logic [CNT_W-1:0]   count;
  logic               pop;

  assign out_valid = count != '0;
  assign out_item  = mem[rptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      if (pop)   rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      count <= count + CNT_W'(wr_en) - CNT_W'(pop);
    end
    if (wr_en) mem[wptr] <= wr_item;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (count != CNT_W'(DEPTH) || pop)) else $error("result queue overflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("result queue count out of range");
`endif

endmodule

`default_nettype wire

// File: sim/heightmap_bilinear_resampler_unit_tb.sv
// Testbench for heightmap_bilinear_resampler_unit: loads sample patches,
// queries terrain points and checks each result against a bit-exact predictor.
// Depends on hbr_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module heightmap_bilinear_resampler_unit_tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 40;

  // Tracks the sample store and config, predicts heights, checks results
  class hbr_scoreboard;
    bit [15:0]   samples [0:hbr_pkg::STORE_DEPTH-1];
    bit          loaded  [0:hbr_pkg::STORE_DEPTH-1];
    logic [8:0]  cfg_sw, cfg_sh;
    bit          cfg_eight, cfg_flip;
    int          cfg_min, cfg_max;
    hbr_pkg::out_item_t heights_due[$];
    int          mismatches;

    function new();
      cfg_sw = 9'd256; cfg_sh = 9'd256; cfg_eight = 1'b0; cfg_flip = 1'b0;
      cfg_min = 0; cfg_max = 256; mismatches = 0;
    endfunction

    function void write_reg(hbr_pkg::cfg_reg_t r, logic [23:0] v);
      case (r)
        hbr_pkg::REG_SOURCE_WIDTH:  cfg_sw = v[8:0];
        hbr_pkg::REG_SOURCE_HEIGHT: cfg_sh = v[8:0];
        hbr_pkg::REG_EIGHT_BIT:     cfg_eight = v[0];
        hbr_pkg::REG_FLIP_VERTICAL: cfg_flip = v[0];
        hbr_pkg::REG_MIN_HEIGHT:    cfg_min = {{8{v[23]}}, v};
        hbr_pkg::REG_MAX_HEIGHT:    cfg_max = {{8{v[23]}}, v};
        default: ;
      endcase
    endfunction

    function int unsigned side_used(logic [8:0] s);
      if (s == 9'd0) return 1;
      if (s > hbr_pkg::MAX_SOURCE_SIDE) return hbr_pkg::MAX_SOURCE_SIDE;
      return 32'(s);
    endfunction

    // Nearest 2^k+1 grid side; ties keep the smaller one
    function int unsigned grid_side(int unsigned s);
      int unsigned c, best, best_d, d;
      best = hbr_pkg::MIN_TARGET_SIDE;
      best_d = 32'hFFFF_FFFF;
      for (c = hbr_pkg::MIN_TARGET_SIDE; c <= hbr_pkg::MAX_TARGET_SIDE;
           c = (c - 1) * 2 + 1) begin
        d = (c > s) ? c - s : s - c;
        if (d < best_d) begin
          best = c;
          best_d = d;
        end
      end
      return best;
    endfunction

    function void map_axis(int unsigned d, int unsigned t, int unsigned s,
                           output int unsigned b, output int unsigned n,
                           output int unsigned f);
      int unsigned num, rem;
      num = d * (s - 1);
      b = num / (t - 1);
      rem = num % (t - 1);
      f = 32'((longint'(rem) << 16) / (t - 1));
      if (b > s - 1) b = s - 1;
      n = (b + 1 < s) ? b + 1 : s - 1;
    endfunction

    // Source neighbours of a target point after saturation and flip
    function void neighbours(logic [10:0] dx_in, logic [10:0] dy_in,
                             output int unsigned x0, output int unsigned x1,
                             output int unsigned y0, output int unsigned y1,
                             output int unsigned tx, output int unsigned ty);
      int unsigned sw, sh, tw, th, dx, dy;
      sw = side_used(cfg_sw); sh = side_used(cfg_sh);
      tw = grid_side(sw);     th = grid_side(sh);
      dx = (dx_in > tw - 1) ? tw - 1 : 32'(dx_in);
      dy = (dy_in > th - 1) ? th - 1 : 32'(dy_in);
      if (cfg_flip) dy = th - 1 - dy;
      map_axis(dx, tw, sw, x0, x1, tx);
      map_axis(dy, th, sh, y0, y1, ty);
    endfunction

    function bit readable(logic [10:0] dx, logic [10:0] dy);
      int unsigned x0, x1, y0, y1, tx, ty;
      neighbours(dx, dy, x0, x1, y0, y1, tx, ty);
      return loaded[y0*256+x0] && loaded[y0*256+x1] &&
             loaded[y1*256+x0] && loaded[y1*256+x1];
    endfunction

    function hbr_pkg::out_item_t predict_height(logic [10:0] dx, logic [10:0] dy);
      hbr_pkg::out_item_t e;
      int unsigned x0, x1, y0, y1, tx, ty;
      longint a, b, c, d, r0, r1, v, w, span, h;
      longint den;
      e.tw = 11'(grid_side(side_used(cfg_sw)));
      e.th = 11'(grid_side(side_used(cfg_sh)));
      if (cfg_max <= cfg_min) begin
        e.height = '0;
        e.rerr = 1'b1;
        return e;
      end
      e.rerr = 1'b0;
      neighbours(dx, dy, x0, x1, y0, y1, tx, ty);
      a = samples[y0*256+x0]; b = samples[y0*256+x1];
      c = samples[y1*256+x0]; d = samples[y1*256+x1];
      r0 = a * 65536 + (b - a) * longint'(tx);
      r1 = c * 65536 + (d - c) * longint'(tx);
      v = r0 * 65536 + (r1 - r0) * longint'(ty);
      if (v < 0) v = 0;
      w = (v + 32768) >>> 16;
      span = longint'(cfg_max) - longint'(cfg_min);
      den = 64'd65535 * 64'd65536;
      h = longint'(cfg_min) + (span * w + den / 2) / den;
      if (h > cfg_max) h = cfg_max;
      e.height = h[23:0];
      return e;
    endfunction

    function void note_item(hbr_pkg::op_t op, logic [7:0] sx, logic [7:0] sy,
                            logic [15:0] smp, logic [10:0] dx, logic [10:0] dy);
      if (op == hbr_pkg::OP_LOAD) begin
        samples[sy*256+sx] = cfg_eight ? 16'(smp[7:0] * 16'd257) : smp;
        loaded[sy*256+sx] = 1'b1;
      end else begin
        heights_due.push_back(predict_height(dx, dy));
      end
    endfunction

    function void check_result(logic [47:0] d, logic u);
      hbr_pkg::out_item_t e;
      if (heights_due.size() == 0) begin
        if (mismatches < 10) $display("result with none expected: tdata %h", d);
        mismatches++;
        return;
      end
      e = heights_due.pop_front();
      if (d[23:0] !== e.height || d[34:24] !== e.tw || d[45:35] !== e.th ||
          u !== e.rerr) begin
        if (mismatches < 10)
          $display("mismatch: exp h %h tw %0d th %0d err %b, got h %h tw %0d th %0d err %b",
                   e.height, e.tw, e.th, e.rerr, d[23:0], d[34:24], d[45:35], u);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        s_axis_tvalid, s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid, m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_valid, cfg_ready;
  logic [hbr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [hbr_pkg::HEIGHT_W-1:0]  cfg_data;

  hbr_scoreboard sb = new();
  int send_idle_pct, stall_pct;
  int idle_cycles = 0;

  heightmap_bilinear_resampler_unit i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver back-pressure
  always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  // Results are taken at the next rising edge; sampled mid-cycle when stable
  always @(negedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser[0]);
  end

  // Watchdog on cycles with no transfer on any channel
  always @(negedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_item(hbr_pkg::op_t op, logic [7:0] sx, logic [7:0] sy,
                           logic [15:0] smp, logic [10:0] dx, logic [10:0] dy);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, dy, dx, smp, sy, sx};
    @(negedge clk);
    while (!s_axis_tready) @(negedge clk);
    @(posedge clk);
    sb.note_item(op, sx, sy, smp, dx, dy);
  endtask

  task automatic write_reg(hbr_pkg::cfg_reg_t r, logic [23:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    sb.write_reg(r, v);
  endtask

  // Let every outstanding query drain, then the pipeline settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.heights_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [8:0] sw, logic [8:0] sh, bit eight, bit flip,
                           int mn, int mx);
    write_reg(hbr_pkg::REG_SOURCE_WIDTH, 24'(sw));
    write_reg(hbr_pkg::REG_SOURCE_HEIGHT, 24'(sh));
    write_reg(hbr_pkg::REG_EIGHT_BIT, 24'(eight));
    write_reg(hbr_pkg::REG_FLIP_VERTICAL, 24'(flip));
    write_reg(hbr_pkg::REG_MIN_HEIGHT, mn[23:0]);
    write_reg(hbr_pkg::REG_MAX_HEIGHT, mx[23:0]);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] edge_coord(int unsigned es);
    int unsigned m;
    m = (es > 4) ? 3 : es - 1;
    return 8'($urandom_range(1) ? $urandom_range(m) : es - 1 - $urandom_range(m));
  endfunction

  // Loads the source samples that lie in both the first or last four rows and the first or last four columns
  task automatic load_patch();
    int unsigned ew, eh, x, y;
    ew = sb.side_used(sb.cfg_sw);
    eh = sb.side_used(sb.cfg_sh);
    for (y = 0; y < eh; y++)
      if (y < 4 || y + 4 >= eh)
        for (x = 0; x < ew; x++)
          if (x < 4 || x + 4 >= ew)
            send_item(hbr_pkg::OP_LOAD, 8'(x), 8'(y), pick_sample(),
                      11'($urandom), 11'($urandom));
  endtask

  task automatic random_items(int n);
    int unsigned ew, eh, tw, th, tries, i;
    logic [10:0] dx, dy;
    ew = sb.side_used(sb.cfg_sw);
    eh = sb.side_used(sb.cfg_sh);
    tw = sb.grid_side(ew);
    th = sb.grid_side(eh);
    for (i = 0; i < n; i++) begin
      case ($urandom_range(19))
        0: send_item(hbr_pkg::OP_LOAD, 8'($urandom), 8'($urandom), pick_sample(),
                     11'($urandom), 11'($urandom));
        1, 2, 3, 4:
          send_item(hbr_pkg::OP_LOAD, edge_coord(ew), edge_coord(eh), pick_sample(),
                    11'($urandom), 11'($urandom));
        default: begin
          tries = 0;
          do begin
            case ($urandom_range(6))
              0: begin dx = 11'($urandom); dy = 11'($urandom); end
              1: begin
                dx = $urandom_range(1) ? 11'(tw - 1) : 11'h7FF;
                dy = $urandom_range(1) ? 11'd0 : 11'(th);
              end
              default: begin
                dx = 11'($urandom_range(tw - 1));
                dy = 11'($urandom_range(th - 1));
              end
            endcase
            tries++;
          end while (!sb.readable(dx, dy) && tries < 50);
          if (!sb.readable(dx, dy)) begin
            dx = 11'd0;
            dy = 11'd0;
          end
          send_item(hbr_pkg::OP_QUERY, 8'($urandom), 8'($urandom), 16'($urandom), dx, dy);
        end
      endcase
    end
  endtask

  task automatic run_phase(int idx, logic [8:0] sw, logic [8:0] sh, bit eight, bit flip,
                           int mn, int mx, int n);
    drain();
    case (idx % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 67; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 67; end
      default: begin send_idle_pct = 12; stall_pct = 12; end
    endcase
    configure(sw, sh, eight, flip, mn, mx);
    load_patch();
    random_items(n);
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = hbr_pkg::OP_LOAD;
    m_axis_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = hbr_pkg::REG_SOURCE_WIDTH;
    cfg_data = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: tiny source, corners, out-of-grid and flipped rows
    configure(9'd3, 9'd2, 1'b0, 1'b0, 0, 256);
    load_patch();
    send_item(hbr_pkg::OP_QUERY, 8'hFF, 8'hFF, 16'hFFFF, 11'd0, 11'd0);
    send_item(hbr_pkg::OP_QUERY, 8'd0, 8'd0, 16'd0, 11'd32, 11'd32);
    send_item(hbr_pkg::OP_QUERY, 8'd0, 8'd0, 16'd0, 11'h7FF, 11'h7FF);
    send_item(hbr_pkg::OP_QUERY, 8'd0, 8'd0, 16'd0, 11'd1024, 11'd0);
    send_item(hbr_pkg::OP_QUERY, 8'd0, 8'd0, 16'd0, 11'd5, 11'd7);
    send_item(hbr_pkg::OP_QUERY, 8'd0, 8'd0, 16'd0, 11'd16, 11'd16);
    send_item(hbr_pkg::OP_LOAD, 8'd1, 8'd1, 16'hFFFF, 11'd0, 11'd0);
    send_item(hbr_pkg::OP_QUERY, 8'd0, 8'd0, 16'd0, 11'd16, 11'd16);
    drain();
    write_reg(hbr_pkg::REG_FLIP_VERTICAL, 24'd1);
    write_reg(hbr_pkg::REG_EIGHT_BIT, 24'd1);
    cfg_valid <= 1'b0;
    send_item(hbr_pkg::OP_LOAD, 8'd0, 8'd0, 16'h12FF, 11'd0, 11'd0);
    send_item(hbr_pkg::OP_QUERY, 8'd0, 8'd0, 16'd0, 11'd0, 11'd0);
    send_item(hbr_pkg::OP_QUERY, 8'd0, 8'd0, 16'd0, 11'd31, 11'd1);
    drain();
    write_reg(hbr_pkg::REG_MAX_HEIGHT, 24'd0);
    cfg_valid <= 1'b0;
    send_item(hbr_pkg::OP_QUERY, 8'd0, 8'd0, 16'd0, 11'd3, 11'd3);

    // Random phases across sizes, modes and height ranges
    run_phase(0, 9'd256, 9'd256, 1'b0, 1'b0, 0, 256, 110);
    run_phase(1, 9'd1, 9'd1, 1'b1, 1'b0, -8388608, 8388607, 110);
    run_phase(2, 9'd0, 9'd511, 1'b0, 1'b1, -1000, 5000, 110);
    run_phase(3, 9'd17, 9'd200, 1'b1, 1'b1, 100, 100, 90);
    run_phase(4, 9'd49, 9'd5, 1'b0, 1'b0, 8388607, -8388608, 90);
    run_phase(5, 9'd100, 9'd33, 1'b1, 1'b0, -8388608, -8388607, 110);
    run_phase(6, 9'd256, 9'd1, 1'b0, 1'b1, -300, 8388607, 110);
    run_phase(7, 9'd2, 9'd97, 1'b0, 1'b0, 0, 65535, 110);
    run_phase(8, 9'($urandom_range(1, 256)), 9'($urandom_range(1, 256)),
              1'($urandom_range(1)), 1'($urandom_range(1)),
              -int'($urandom_range(100000)), int'($urandom_range(100000)), 110);
    run_phase(9, 9'($urandom_range(1, 64)), 9'($urandom_range(1, 64)),
              1'($urandom_range(1)), 1'($urandom_range(1)),
              -int'($urandom_range(8000000)), int'($urandom_range(8000000)), 110);
    drain();

    if (sb.mismatches == 0 && sb.heights_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
